[design/firpt_pkg.sv]
// Shared types and constants for the programmable-tap FIR filter.
// Used by firpt_ctrl, firpt_datapath, the top level and the checker.
`timescale 1ns / 1ps

package firpt_pkg;

    localparam int COEF_W    = 16;   // coefficient width, Q1.15
    localparam int OUT_W     = 16;   // filtered output width, Q1.15
    localparam int FRAC_BITS = 15;   // fraction bits dropped after the sum
    localparam int TAPCNT_W  = 5;    // tap_count register width
    localparam int IDX_W     = 4;    // coef_index field width

    localparam logic [COEF_W-1:0]   COEF0_RESET     = 16'h7fff;
    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = 5'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_COEF   = 1'b1
    } t_action;

    typedef struct packed {
        logic start;     // new sample: push history, clear accumulator
        logic coef_wr;   // write one coefficient, clear history
        logic issue;     // read one tap and advance the tap counter
        logic out_load;  // load the output register from the accumulator
    } t_dp_cmd;

    typedef struct packed {
        logic no_taps;   // effective tap count is zero
        logic last_tap;  // tap counter sits on the last tap in use
        logic busy;      // MAC pipeline still holds a product
    } t_dp_status;

endpackage

[design/firpt_ctrl.sv]
// Controller for the FIR filter: input/output handshake and MAC sequencing.
// Depends on firpt_pkg; drives firpt_datapath through t_dp_cmd.
`timescale 1ns / 1ps

module firpt_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_action,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    input  firpt_pkg::t_dp_status  i_status,
    output firpt_pkg::t_dp_cmd     o_cmd
);

    firpt_pkg::t_state r_state, n_state;
    logic              r_out_vld, n_out_vld;
    logic              s_accept;
    logic              out_free;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= firpt_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_out_vld  = r_out_vld && !i_m_tready;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            firpt_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (s_accept) begin
                    if (firpt_pkg::t_action'(i_action) == firpt_pkg::ACT_COEF) begin
                        o_cmd.coef_wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state = i_status.no_taps ? firpt_pkg::ST_DONE
                                                   : firpt_pkg::ST_RUN;
                    end
                end
            end
            firpt_pkg::ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_tap) begin
                    n_state = firpt_pkg::ST_DRAIN;
                end
            end
            firpt_pkg::ST_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = firpt_pkg::ST_DONE;
                end
            end
            firpt_pkg::ST_DONE: begin
                // hold the sum until the previous word has left
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = firpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = firpt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_vld;

endmodule

[design/firpt_datapath.sv]
// Datapath for the FIR filter: history and coefficient memories, tap counter,
// three-stage multiply-accumulate and the shift/saturate output register.
// Depends on firpt_pkg; controlled by firpt_ctrl.
`timescale 1ns / 1ps

module firpt_datapath #(
    parameter int TAPS        = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [firpt_pkg::TAPCNT_W-1:0]       i_cfg_wdata,
    input  firpt_pkg::t_dp_cmd                   i_cmd,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic [firpt_pkg::IDX_W-1:0]          i_coef_index,
    input  logic signed [firpt_pkg::COEF_W-1:0]  i_coef_value,
    output firpt_pkg::t_dp_status                o_status,
    output logic signed [firpt_pkg::OUT_W-1:0]   o_filtered,
    output logic                                 o_saturated
);

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW    = $clog2(TAPS + 1);
    localparam int PW    = SAMPLE_BITS + firpt_pkg::COEF_W;
    localparam int ACC_W = PW + $clog2(TAPS) + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    // memories
    logic signed [SAMPLE_BITS-1:0]    hist_mem [TAPS];
    logic signed [firpt_pkg::COEF_W-1:0] coef_mem [TAPS];
    logic [TAPS-1:0]                  r_coef_vld;

    // control state
    logic [firpt_pkg::TAPCNT_W-1:0]   r_tap_count;
    logic [AW-1:0]                    r_pos;      // slot for the next sample
    logic [AW-1:0]                    r_newest;   // slot of the current sample
    logic [CW-1:0]                    r_fill;     // samples held since clear
    logic [CW-1:0]                    r_tap;
    logic                             r_v1, r_v2;

    // pipeline payload
    logic signed [SAMPLE_BITS-1:0]    r_hist_rd;
    logic signed [firpt_pkg::COEF_W-1:0] r_coef_rd;
    logic                             r_coef_ok;
    logic                             r_coef_is0;
    logic                             r_tap_live;
    logic signed [PW-1:0]             r_prod;
    logic signed [ACC_W-1:0]          r_acc;
    logic signed [firpt_pkg::OUT_W-1:0] r_out_data;
    logic                             r_out_sat;

    logic [CW-1:0]                    n_eff;
    logic [AW-1:0]                    tap_idx;
    logic [AW:0]                      hist_sum;
    logic [AW-1:0]                    hist_addr;
    logic signed [SAMPLE_BITS-1:0]    samp_eff;
    logic signed [firpt_pkg::COEF_W-1:0] coef_eff;
    logic signed [ACC_W-1:0]          acc_q;
    logic                             sat_hi, sat_lo;

    always_comb begin
        n_eff = (32'(r_tap_count) > TAPS) ? CW'(TAPS) : CW'(r_tap_count);
    end

    assign tap_idx = r_tap[AW-1:0];

    // newest minus tap, modulo TAPS
    always_comb begin
        hist_sum  = {1'b0, r_newest} + (AW + 1)'(TAPS) - {1'b0, tap_idx};
        hist_addr = (hist_sum >= (AW + 1)'(TAPS)) ? AW'(hist_sum - (AW + 1)'(TAPS))
                                                  : AW'(hist_sum);
    end

    assign o_status.no_taps  = (n_eff == '0);
    assign o_status.last_tap = (r_tap == n_eff - CW'(1));
    assign o_status.busy     = r_v1 || r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= firpt_pkg::TAP_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_newest   <= '0;
            r_fill     <= '0;
            r_tap      <= '0;
            r_coef_vld <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.start) begin
                r_newest <= r_pos;
                r_pos    <= (r_pos == AW'(TAPS - 1)) ? '0 : r_pos + AW'(1);
                r_fill   <= (r_fill == CW'(TAPS)) ? r_fill : r_fill + CW'(1);
                r_tap    <= '0;
            end else if (i_cmd.issue) begin
                r_tap <= r_tap + CW'(1);
            end
            if (i_cmd.coef_wr) begin
                // history clear: fill count back to zero
                r_pos  <= '0;
                r_fill <= '0;
                if (32'(i_coef_index) < TAPS) begin
                    r_coef_vld[AW'(i_coef_index)] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            hist_mem[r_pos] <= i_sample;
        end
        if (i_cmd.coef_wr && (32'(i_coef_index) < TAPS)) begin
            coef_mem[AW'(i_coef_index)] <= i_coef_value;
        end
        if (i_cmd.issue) begin
            r_hist_rd  <= hist_mem[hist_addr];
            r_coef_rd  <= coef_mem[tap_idx];
            r_coef_ok  <= r_coef_vld[tap_idx];
            r_coef_is0 <= (tap_idx == '0);
            r_tap_live <= (r_tap < r_fill);
        end
    end

    // stage 2: select reset defaults, multiply
    always_comb begin
        samp_eff = r_tap_live ? r_hist_rd : '0;
        if (r_coef_ok) begin
            coef_eff = r_coef_rd;
        end else begin
            coef_eff = r_coef_is0 ? firpt_pkg::COEF0_RESET : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= samp_eff * coef_eff;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // arithmetic shift rounds toward minus infinity
    always_comb begin
        acc_q  = r_acc >>> firpt_pkg::FRAC_BITS;
        sat_hi = (acc_q > SAT_HI);
        sat_lo = (acc_q < SAT_LO);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            priority if (sat_hi) begin
                r_out_data <= firpt_pkg::OUT_W'(32767);
            end else if (sat_lo) begin
                r_out_data <= firpt_pkg::OUT_W'(-32768);
            end else begin
                r_out_data <= acc_q[firpt_pkg::OUT_W-1:0];
            end
            r_out_sat <= sat_hi || sat_lo;
        end
    end

    assign o_filtered  = r_out_data;
    assign o_saturated = r_out_sat;

endmodule

[design/fir_filter_programmable_taps.sv]
// Top level of the programmable-tap FIR filter.
// Depends on firpt_pkg, firpt_ctrl and firpt_datapath.
//
// Input stream (s side): one word per item. tuser is the action: a sample
// word (0) pushes sample_in into the history and produces one output word;
// a coefficient word (1) writes coef_value into slot coef_index, clears the
// history and produces nothing. Slots at or beyond TAPS are not written.
// Output stream (m side): filtered in tdata, the saturation flag in tuser.
// i_cfg_we/i_cfg_wdata write tap_count (taps in use, clipped to TAPS);
// write it only while the filter is idle.
// Sequence: with taps in use a sample holds the input through accept, one multiply
// per tap on one shared multiplier, the MAC drain and the output load. The result
// and the next ready appear together, registered from the output load; with zero
// taps the sample goes straight to the output load. A coefficient word leaves it idle.
// Reset (synchronous, active low) clears the history, sets coefficient 0
// to 32767 and the rest to zero, and sets tap_count to 1.
// A stalled output word is held in the output register; the filter still
// accepts and computes the next sample and waits only to hand its result on.
`timescale 1ns / 1ps

module fir_filter_programmable_taps #(
    parameter int TAPS        = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [firpt_pkg::TAPCNT_W-1:0]      i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [SAMPLE_BITS-1:0] sample_in, then coef_index (4), coef_value (16), zero pad
    input  logic [((SAMPLE_BITS + firpt_pkg::IDX_W + firpt_pkg::COEF_W + 7) / 8) * 8 - 1:0]
                                                i_s_tdata,
    input  logic                                i_s_tuser,    // action
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [firpt_pkg::OUT_W-1:0]         o_m_tdata,    // filtered
    output logic                                o_m_tuser     // saturated
);

    localparam int IDX_LO  = SAMPLE_BITS;
    localparam int COEF_LO = SAMPLE_BITS + firpt_pkg::IDX_W;

    firpt_pkg::t_dp_cmd    cmd;
    firpt_pkg::t_dp_status status;
    logic signed [firpt_pkg::OUT_W-1:0] filtered;

    firpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    firpt_datapath #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .i_sample     ($signed(i_s_tdata[SAMPLE_BITS-1:0])),
        .i_coef_index (i_s_tdata[IDX_LO +: firpt_pkg::IDX_W]),
        .i_coef_value ($signed(i_s_tdata[COEF_LO +: firpt_pkg::COEF_W])),
        .o_status     (status),
        .o_filtered   (filtered),
        .o_saturated  (o_m_tuser)
    );

    assign o_m_tdata = filtered;

endmodule

[design/firpt_checker.sv]
// Port-level checks for the programmable-tap FIR filter, bound to the top.
// Depends on firpt_pkg and fir_filter_programmable_taps.
`timescale 1ns / 1ps

module firpt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         i_s_tready,
    input logic                         i_s_tuser,
    input logic                         i_m_tvalid,
    input logic                         i_m_tready,
    input logic [firpt_pkg::OUT_W-1:0]  i_m_tdata,
    input logic                         i_m_tuser
);

    logic s_accept;
    assign s_accept = i_s_tvalid && i_s_tready;

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled output word changed");

    // a clipped result can only sit at one of the two rails
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> (i_m_tdata == 16'h7fff) || (i_m_tdata == 16'h8000))
        else $error("saturation flag without a rail value");

    // after a coefficient write the input is ready again in the next cycle
    a_coef_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (i_s_tuser == firpt_pkg::ACT_COEF) |=> i_s_tready)
        else $error("coefficient write did not return to ready");

    // a sample starts the MAC run (or, with zero taps, the output load), so the input closes
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (i_s_tuser == firpt_pkg::ACT_SAMPLE) |=> !i_s_tready)
        else $error("ready stayed high after a sample word");

endmodule

bind fir_filter_programmable_taps firpt_checker u_firpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);

[tb/tb.sv]
// Self-checking bench for fir_filter_programmable_taps: a directed table, then random
// phases with idle, stall and back-pressure patterns, scored against an in-bench predictor.
// Depends on firpt_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb;

    localparam int TAPS          = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int TDATA_W       =
        ((SAMPLE_BITS + firpt_pkg::IDX_W + firpt_pkg::COEF_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = TAPS + 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 100;
    localparam int DIR_ROWS      = 23;
    localparam int PHASE_TAPS [PHASES] = '{16, 5, 1, 31, 0, 9, 16, 2};

    typedef struct packed {
        logic [firpt_pkg::OUT_W-1:0] filtered;
        logic                        saturated;
    } t_fir_out;

    typedef enum logic {
        ROW_WORD,
        ROW_TAPS
    } t_row_kind;

    typedef struct {
        t_row_kind           kind;
        firpt_pkg::t_action  act;
        logic [15:0]         data;   // sample_in or coef_value, by action
        logic [3:0]          idx;
        logic [4:0]          taps;
        bit                  typed;
        t_fir_out            res;
    } t_dir_row;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [firpt_pkg::TAPCNT_W-1:0] i_cfg_wdata = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [TDATA_W-1:0]             i_s_tdata   = '0;
    logic                           i_s_tuser   = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [firpt_pkg::OUT_W-1:0]    o_m_tdata;
    logic                           o_m_tuser;

    always #4 i_clk = ~i_clk;

    fir_filter_programmable_taps #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // filter shadow state
    logic signed [15:0]  hist [TAPS];
    logic [3:0]          hist_wr_pos;
    logic signed [15:0]  coef_tab [TAPS];
    logic [4:0]          taps_in_use;

    t_fir_out filtered_q [$];
    int       err_count     = 0;
    int       idle_pct      = 0;
    int       stall_pct     = 0;
    int       hold_requests = 0;

    function automatic void add_expected(t_fir_out w);
        filtered_q = {filtered_q, w};
    endfunction

    function automatic bit fir_predict(firpt_pkg::t_action act, logic [15:0] smp,
                                       logic [3:0] idx, logic [15:0] cval,
                                       output t_fir_out res);
        longint acc;
        longint q;
        int     n;
        int     slot;
        res = '0;
        if (act == firpt_pkg::ACT_COEF) begin
            coef_tab[idx] = cval;
            foreach (hist[i]) hist[i] = '0;
            hist_wr_pos = '0;
            return 1'b0;
        end
        hist[hist_wr_pos] = smp;
        n = (taps_in_use > TAPS) ? TAPS : taps_in_use;
        acc = 0;
        for (int i = 0; i < n; i++) begin
            slot = (hist_wr_pos + TAPS - i) % TAPS;
            acc += longint'(hist[slot]) * longint'(coef_tab[i]);
        end
        hist_wr_pos = hist_wr_pos + 4'd1;
        q = acc >>> firpt_pkg::FRAC_BITS;   // floor division
        if (q > 32767) begin
            res.filtered  = 16'h7fff;
            res.saturated = 1'b1;
        end else if (q < -32768) begin
            res.filtered  = 16'h8000;
            res.saturated = 1'b1;
        end else begin
            res.filtered = q[15:0];
        end
        return 1'b1;
    endfunction

    function automatic logic [15:0] rand_q15(int small_pct);
        int r;
        r = $urandom_range(99);
        if (r < 12) begin
            case ($urandom_range(3))
                0:       return 16'h8000;
                1:       return 16'h7fff;
                2:       return 16'hffff;
                default: return 16'h0000;
            endcase
        end
        if (r < 12 + small_pct) return 16'($signed($urandom_range(8191)) - 4096);
        return 16'($urandom);
    endfunction

    // unused field of the word is randomized; the filter must ignore it
    task automatic send_word(firpt_pkg::t_action act, logic [15:0] data, logic [3:0] idx,
                             bit typed, t_fir_out typed_res);
        t_fir_out    res;
        logic [15:0] smp;
        logic [15:0] cval;
        logic [3:0]  slot;
        smp  = (act == firpt_pkg::ACT_SAMPLE) ? data : 16'($urandom);
        cval = (act == firpt_pkg::ACT_COEF) ? data : 16'($urandom);
        slot = (act == firpt_pkg::ACT_COEF) ? idx : 4'($urandom);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {4'b0, cval, slot, smp};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (fir_predict(act, smp, slot, cval, res))
            add_expected(typed ? typed_res : res);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (filtered_q.size() != 0) @(posedge i_clk);
        // a coefficient word gives no result, so allow the pipeline to settle
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tap_count(logic [4:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        taps_in_use = v;
    endtask

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h7fff, 4'd0,  5'd0,  1'b1, '{16'h7ffe, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h8000, 4'd0,  5'd0,  1'b1, '{16'h8001, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h0000, 4'd0,  5'd0,  1'b1, '{16'h0000, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'hffff, 4'd0,  5'd0,  1'b1, '{16'hffff, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_COEF,   16'h8000, 4'd0,  5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h8000, 4'd0,  5'd0,  1'b1, '{16'h7fff, 1'b1}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h7fff, 4'd0,  5'd0,  1'b1, '{16'h8001, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_COEF,   16'h7fff, 4'd15, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_COEF,   16'h7fff, 4'd1,  5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_TAPS, firpt_pkg::ACT_SAMPLE, 16'h0000, 4'd0,  5'd31, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h8000, 4'd0,  5'd0,  1'b1, '{16'h7fff, 1'b1}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h8000, 4'd0,  5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h7fff, 4'd0,  5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h1234, 4'd0,  5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_TAPS, firpt_pkg::ACT_SAMPLE, 16'h0000, 4'd0,  5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h1234, 4'd0,  5'd0,  1'b1, '{16'h0000, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h8000, 4'd0,  5'd0,  1'b1, '{16'h0000, 1'b0}},
        '{ROW_TAPS, firpt_pkg::ACT_SAMPLE, 16'h0000, 4'd0,  5'd16, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_COEF,   16'h8000, 4'd1,  5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h7fff, 4'd0,  5'd0,  1'b1, '{16'h8001, 1'b0}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'h7fff, 4'd0,  5'd0,  1'b1, '{16'h8000, 1'b1}},
        '{ROW_WORD, firpt_pkg::ACT_SAMPLE, 16'ha5a5, 4'd0,  5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_TAPS, firpt_pkg::ACT_SAMPLE, 16'h0000, 4'd0,  5'd1,  1'b0, '{16'h0000, 1'b0}}
    };

    // output side: random stalls plus long hold-offs on request
    int hold_served = 0;
    int hold_left   = 0;
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_served + 1;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_fir_out want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (filtered_q.size() == 0) begin
                $error("unexpected output word: filtered %h saturated %b",
                       o_m_tdata, o_m_tuser);
                err_count = err_count + 1;
            end else begin
                want = filtered_q.pop_front();
                if (o_m_tdata !== want.filtered) begin
                    $error("filtered: expected %h, got %h", want.filtered, o_m_tdata);
                    err_count = err_count + 1;
                end
                if (o_m_tuser !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated, o_m_tuser);
                    err_count = err_count + 1;
                end
            end
        end
    end

    initial begin
        #4_800_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int         guard;
        int         mode;
        logic [4:0] taps;

        foreach (hist[i]) hist[i] = '0;
        foreach (coef_tab[i]) coef_tab[i] = '0;
        coef_tab[0] = firpt_pkg::COEF0_RESET;
        hist_wr_pos = '0;
        taps_in_use = firpt_pkg::TAP_COUNT_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_TAPS)
                write_tap_count(dir_rows[r].taps);
            else
                send_word(dir_rows[r].act, dir_rows[r].data, dir_rows[r].idx,
                          dir_rows[r].typed, dir_rows[r].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            taps = (p == PHASES - 1) ? 5'($urandom_range(31)) : 5'(PHASE_TAPS[p]);
            write_tap_count(taps);
            mode = p % 4;
            idle_pct  = (mode == 1) ? 54 : (mode == 3) ? 12 : 0;
            stall_pct = (mode == 2) ? 54 : (mode == 3) ? 12 : 0;
            // load the whole table, then stream samples with a stray reload now and then
            for (int k = 0; k < TAPS; k++)
                send_word(firpt_pkg::ACT_COEF, rand_q15(50), 4'(k), 1'b0, '0);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == 0 && k == 40)
                    hold_requests = hold_requests + 1;
                if (p == 0 && k == 70)
                    wait_drained();
                if ($urandom_range(99) < 6)
                    send_word(firpt_pkg::ACT_COEF, rand_q15(50), 4'($urandom), 1'b0, '0);
                else
                    send_word(firpt_pkg::ACT_SAMPLE, rand_q15(30), 4'd0, 1'b0, '0);
            end
        end

        i_s_tvalid <= 1'b0;
        guard = 0;
        while (filtered_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard = guard + 1;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (filtered_q.size() != 0) begin
            $error("%0d output words never arrived", filtered_q.size());
            err_count = err_count + 1;
        end
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
